FILE: hdl/sdtq_pkg.sv
// shared types and codes for the sorted deadline timer queue
// no dependencies
`timescale 1ns / 1ps
package sdtq_pkg;
  localparam logic [2:0] KIND_ADD_LATER = 3'd0;
  localparam logic [2:0] KIND_ADD_FIRST = 3'd1;
  localparam logic [2:0] KIND_FULL      = 3'd2;
  localparam logic [2:0] KIND_FIRED     = 3'd3;
  localparam logic [2:0] KIND_RELOAD    = 3'd4;
  localparam logic [2:0] KIND_STOP      = 3'd5;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam int unsigned REG_TPS = 0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ADD, ST_HEADRD, ST_HEADCMP, ST_WALKRD, ST_WALKCMP,
    ST_LINK, ST_CHKRD, ST_CHKCMP, ST_FINAL
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic mul;        // register product
    logic add;        // form deadline, pick free slot
    logic rd_head;    // read entry at head
    logic rd_next;    // read entry after cursor
    logic adv;        // cursor moves to the entry read
    logic ins_head;   // link new entry at head
    logic ins_after;  // link new entry after cursor
    logic pop;        // free head entry
    logic emit;       // result strobe
    logic [2:0] kind;
    logic last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cmd;
    logic full;
    logic nonempty;
    logic rd_le;       // entry read has deadline <= key
    logic cur_linked;  // cursor has a successor
  } stat_t;
endpackage

FILE: hdl/sorted_deadline_timer_queue.sv
// top level of the sorted deadline timer queue: apb register, controller, datapath
// depends on sdtq_pkg, sdtq_ctrl, sdtq_dp
//
// channel   direction  signals                                  beat
// item      in         start/busy, command now seconds tag      start & !busy
// result    out        done, kind slot fired_tag interval last  done (no stall)
// config    in         apb psel penable pwrite paddr pwdata     write access phase
//
// add: the result is emitted in ST_HEADCMP when the entry goes first, else in ST_LINK
// after walking past the earlier entries; a full pool answers from ST_MUL
// the walk reads one list entry in ST_WALKRD and compares it in ST_WALKCMP
// check: an empty queue answers from ST_CHKRD, else ST_CHKRD and ST_CHKCMP repeat per fired entry;
// one result per fired entry
// reset clears the busy and link valid bits at once; no clearing pass
// the receiver cannot stall; a new item is taken in the cycle of the last result
`timescale 1ns / 1ps
module sorted_deadline_timer_queue #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [63:0] now,
  input  logic [31:0] seconds,
  input  logic [15:0] tag,
  output logic        done,
  output logic [2:0]  kind,
  output logic [3:0]  slot,
  output logic [15:0] fired_tag,
  output logic [63:0] interval,
  output logic        last
);
  import sdtq_pkg::*;

  logic [31:0] ticks_per_second;
  cmd_t cm;
  stat_t st;

  assign pready = 1'b1;
  // only register 0 exists at byte address 0
  assign prdata = (paddr == 2'(REG_TPS * 4)) ? ticks_per_second : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= 32'd19200000;
    end else if (psel && penable && pwrite && paddr == 2'(REG_TPS * 4)) begin
      ticks_per_second <= pwdata;
    end
  end

  sdtq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .st(st), .cm(cm)
  );

  sdtq_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cm(cm), .st(st),
    .command(command), .now(now), .seconds(seconds), .tag(tag),
    .tps(ticks_per_second),
    .done(done), .kind(kind), .slot(slot), .fired_tag(fired_tag),
    .interval(interval), .last(last)
  );

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (done && last) |-> !$past(start && !busy)) else $error("result at item accept");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without an item in flight");
  a_start_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done) else $error("result right after accept");
endmodule

FILE: hdl/sdtq_ctrl.sv
// control sequencer for add and check walks
// depends on sdtq_pkg
`timescale 1ns / 1ps
module sdtq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  sdtq_pkg::stat_t st,
  output sdtq_pkg::cmd_t  cm
);
  import sdtq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cm = '0;
    busy = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cm.load = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (st.cmd == CMD_CHECK) begin
          state_next = ST_CHKRD;
        end else if (st.full) begin
          cm.emit = 1'b1;
          cm.kind = KIND_FULL;
          cm.last = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cm.mul = 1'b1;
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        cm.add = 1'b1;
        state_next = ST_HEADRD;
      end
      ST_HEADRD: begin
        cm.rd_head = 1'b1;
        state_next = ST_HEADCMP;
      end
      ST_HEADCMP: begin
        // new entry goes first unless head deadline <= new deadline
        if (!st.nonempty || !st.rd_le) begin
          cm.ins_head = 1'b1;
          cm.emit = 1'b1;
          cm.kind = KIND_ADD_FIRST;
          cm.last = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cm.adv = 1'b1;
          state_next = ST_WALKRD;
        end
      end
      ST_WALKRD: begin
        if (st.cur_linked) begin
          cm.rd_next = 1'b1;
          state_next = ST_WALKCMP;
        end else begin
          state_next = ST_LINK;
        end
      end
      ST_WALKCMP: begin
        if (st.rd_le) begin
          cm.adv = 1'b1;
          state_next = ST_WALKRD;
        end else begin
          state_next = ST_LINK;
        end
      end
      ST_LINK: begin
        cm.ins_after = 1'b1;
        cm.emit = 1'b1;
        cm.kind = KIND_ADD_LATER;
        cm.last = 1'b1;
        state_next = ST_IDLE;
      end
      ST_CHKRD: begin
        if (st.nonempty) begin
          cm.rd_head = 1'b1;
          state_next = ST_CHKCMP;
        end else begin
          cm.emit = 1'b1;
          cm.kind = KIND_STOP;
          cm.last = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CHKCMP: begin
        if (st.rd_le) begin
          cm.pop = 1'b1;
          cm.emit = 1'b1;
          cm.kind = KIND_FIRED;
          state_next = ST_CHKRD;
        end else begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cm.emit = 1'b1;
        cm.kind = KIND_RELOAD;
        cm.last = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    cm.emit |-> busy) else $error("result outside an item");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cm.emit && cm.last) |=> !busy) else $error("no return to idle after last");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cm.ins_head, cm.ins_after, cm.pop})) else $error("two list ops");
endmodule

FILE: hdl/sdtq_dp.sv
// slot pool, linked deadline list and arithmetic
// depends on sdtq_pkg
`timescale 1ns / 1ps
module sdtq_dp #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  sdtq_pkg::cmd_t  cm,
  output sdtq_pkg::stat_t st,
  input  logic            command,
  input  logic [63:0]     now,
  input  logic [31:0]     seconds,
  input  logic [15:0]     tag,
  input  logic [31:0]     tps,
  output logic            done,
  output logic [2:0]      kind,
  output logic [3:0]      slot,
  output logic [15:0]     fired_tag,
  output logic [63:0]     interval,
  output logic            last
);
  import sdtq_pkg::*;

  localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [SLOT_COUNT-1:0] busy_v, lvalid;
  logic [63:0] dl_mem [SLOT_COUNT];
  logic [15:0] tag_mem [SLOT_COUNT];
  logic [SW-1:0] nx_mem [SLOT_COUNT];
  logic [SW-1:0] head, cur, nslot, rd_slot;
  logic nonempty;

  logic c_cmd;
  logic [63:0] c_now, prod, key;
  logic [31:0] c_secs;
  logic [15:0] c_tag;
  logic [63:0] rd_dl;
  logic [15:0] rd_tag;
  logic [SW-1:0] rd_nx;
  logic rd_lv;
  logic [63:0] diff;

  // lowest free slot
  logic [SW-1:0] free_idx;
  logic full;
  always_comb begin
    free_idx = '0;
    full = 1'b1;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!busy_v[i]) begin
        free_idx = SW'(i);
        full = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cm.load) begin
      c_cmd <= command;
      c_now <= now;
      c_secs <= seconds;
      c_tag <= tag;
    end
    if (cm.mul) prod <= 64'(tps) * 64'(c_secs);
    if (cm.add) begin
      key <= c_now + prod;
      nslot <= free_idx;
    end
    if (cm.load && command == CMD_CHECK) key <= now;
    if (cm.rd_head || cm.rd_next) begin
      rd_slot <= cm.rd_head ? head : nx_mem[cur];
      rd_dl <= dl_mem[cm.rd_head ? head : nx_mem[cur]];
      rd_tag <= tag_mem[cm.rd_head ? head : nx_mem[cur]];
      rd_nx <= nx_mem[cm.rd_head ? head : nx_mem[cur]];
      rd_lv <= lvalid[cm.rd_head ? head : nx_mem[cur]];
    end
    if (cm.adv) cur <= rd_slot;
    if (cm.ins_head) begin
      dl_mem[nslot] <= key;
      tag_mem[nslot] <= c_tag;
      nx_mem[nslot] <= head;
    end
    if (cm.ins_after) begin
      dl_mem[nslot] <= key;
      tag_mem[nslot] <= c_tag;
      nx_mem[nslot] <= nx_mem[cur];
      nx_mem[cur] <= nslot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_v <= '0;
      lvalid <= '0;
      head <= '0;
      nonempty <= 1'b0;
    end else begin
      if (cm.ins_head) begin
        busy_v[nslot] <= 1'b1;
        lvalid[nslot] <= nonempty;
        head <= nslot;
        nonempty <= 1'b1;
      end
      if (cm.ins_after) begin
        busy_v[nslot] <= 1'b1;
        lvalid[nslot] <= lvalid[cur];
        lvalid[cur] <= 1'b1;
      end
      if (cm.pop) begin
        busy_v[rd_slot] <= 1'b0;
        lvalid[rd_slot] <= 1'b0;
        if (rd_lv) begin
          head <= rd_nx;
        end else begin
          head <= '0;
          nonempty <= 1'b0;
        end
      end
    end
  end

  assign diff = rd_dl - key;

  always_comb begin
    st.cmd = c_cmd;
    st.full = full;
    st.nonempty = nonempty;
    st.rd_le = (rd_dl <= key);
    st.cur_linked = lvalid[cur];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cm.emit;
    end
    kind <= cm.kind;
    last <= cm.last;
    slot <= '0;
    fired_tag <= '0;
    interval <= '0;
    case (cm.kind)
      KIND_ADD_FIRST: begin
        slot <= 4'(nslot);
        interval <= (key == c_now) ? 64'd1 : key - c_now;
      end
      KIND_ADD_LATER: slot <= 4'(nslot);
      KIND_FIRED: begin
        slot <= 4'(rd_slot);
        fired_tag <= rd_tag;
      end
      KIND_RELOAD: interval <= (diff == 64'd0) ? 64'd1 : diff;
      default: ;
    endcase
  end

  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    cm.pop |-> busy_v[rd_slot]) else $error("pop of free slot");
  a_ins_free: assert property (@(posedge clk) disable iff (rst)
    (cm.ins_head || cm.ins_after) |-> !busy_v[nslot]) else $error("insert into busy slot");
  a_empty_free: assert property (@(posedge clk) disable iff (rst)
    !nonempty |-> (busy_v == '0)) else $error("busy slot with empty queue");
endmodule
